/* src/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and codes of the resource slot pool.
// ----------------------------------------------------------------------------
package rsp_pkg;

   localparam int unsigned DEFAULT_CAP = 8;
   localparam int unsigned MASK_BITS   = 16;

   localparam logic [2:0] OP_ACQUIRE = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_SWEEP   = 3'd2;
   localparam logic [2:0] OP_PREWARM = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_CREATE    = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic CSR_ACTIVE_SLOTS = 1'b0;
   localparam logic CSR_IDLE_LIMIT   = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  slot_handle;
      logic [15:0] valid_mask;
      logic [15:0] create_mask;
      logic [4:0]  prewarm_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic [31:0] slot_use_count;
      logic [4:0]  changed_count;
      logic [4:0]  available;
      logic [4:0]  busy_total;
      logic [4:0]  idle_total;
      logic [31:0] acquired_total;
      logic [31:0] released_total;
      logic [31:0] failure_total;
      logic [31:0] full_total;
   } rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

/* src/rsp_req_if.sv */
// ----------------------------------------------------------------------------
// rsp_req_if
// Request channel: operation beat with masks and handle.
// ----------------------------------------------------------------------------
interface rsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [3:0]  slot_handle;
   logic [15:0] valid_mask;
   logic [15:0] create_mask;
   logic [4:0]  prewarm_limit;

   modport source (output valid, operation, slot_handle, valid_mask, create_mask,
                   prewarm_limit, input ready);
   modport sink   (input valid, operation, slot_handle, valid_mask, create_mask,
                   prewarm_limit, output ready);
endinterface

/* src/rsp_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsp_rsp_if
// Response channel: one result beat per request.
// ----------------------------------------------------------------------------
interface rsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  slot_index;
   logic [31:0] slot_use_count;
   logic [4:0]  changed_count;
   logic [4:0]  available;
   logic [4:0]  busy_total;
   logic [4:0]  idle_total;
   logic [31:0] acquired_total;
   logic [31:0] released_total;
   logic [31:0] failure_total;
   logic [31:0] full_total;

   modport source (output valid, status, slot_index, slot_use_count, changed_count,
                   available, busy_total, idle_total, acquired_total,
                   released_total, failure_total, full_total, input ready);
   modport sink   (input valid, status, slot_index, slot_use_count, changed_count,
                   available, busy_total, idle_total, acquired_total,
                   released_total, failure_total, full_total, output ready);
endinterface

/* src/rsp_ram.sv */
// ----------------------------------------------------------------------------
// rsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* src/rsp_core.sv */
// ----------------------------------------------------------------------------
// rsp_core
// Slot scan sequencer: slot flags, counters and the tick and use-count RAMs.
// ----------------------------------------------------------------------------
module rsp_core
   import rsp_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_type                           req,
   input  logic [$clog2(NUM_SLOTS+1)-1:0]    cap,
   input  logic [15:0]                       idle_limit,
   output logic                              done,
   input  logic                              taken,
   output rsp_type                           result
);
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int WW = (CW > 5) ? CW : 5;

   typedef enum logic [3:0] {
      S_IDLE, S_ACQ0, S_ACQ1, S_USE_RD, S_USE_WR, S_REL,
      S_SW_RD, S_SW_CK, S_PRE, S_DONE
   } state_type;

   state_type       state_ff;
   req_type         req_ff;
   logic [IW-1:0]   idx_ff, index_ff;
   logic            reuse_ff;
   logic [1:0]      status_ff;
   logic [31:0]     uses_ff;
   logic [CW-1:0]   changed_ff, busy_cnt_ff, idle_cnt_ff;
   logic [31:0]     now_ff;
   logic [31:0]     stat_ff [4];
   logic [NUM_SLOTS-1:0] busy_ff, holds_ff, uvld_ff;

   logic            last;
   logic            vbit, cbit;
   logic [63:0]     vm64, cm64;
   logic [CW-1:0]   changed_in;

   logic            tick_we;
   logic [IW-1:0]   tick_waddr, tick_raddr;
   logic [31:0]     tick_rdata;
   logic            use_we;
   logic [31:0]     use_wdata, use_rdata, use_cur;

   assign last = (CW'(CW'(idx_ff) + CW'(1)) == cap);
   assign vm64 = 64'(req_ff.valid_mask);
   assign cm64 = 64'(req_ff.create_mask);
   assign vbit = vm64[6'(idx_ff)];
   assign cbit = cm64[6'(idx_ff)];
   assign changed_in = CW'(changed_ff + CW'(1));
   assign use_cur = uvld_ff[index_ff] ? use_rdata : 32'd0;
   assign use_wdata = sat_inc(use_cur);

   always_comb begin
      tick_we = 1'b0;
      tick_waddr = idx_ff;
      if (state_ff == S_REL) begin
         tick_waddr = IW'(req_ff.slot_handle);
         tick_we = (8'(req_ff.slot_handle) < 8'(cap))
                   && busy_ff[IW'(req_ff.slot_handle)];
      end else if (state_ff == S_PRE) begin
         tick_we = !holds_ff[idx_ff] && cbit;
      end
   end

   assign tick_raddr = idx_ff;
   assign use_we = (state_ff == S_USE_WR);

   rsp_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_tick_ram (
      .clock (clock), .we (tick_we), .waddr (tick_waddr), .wdata (now_ff),
      .raddr (tick_raddr), .rdata (tick_rdata)
   );

   rsp_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_use_ram (
      .clock (clock), .we (use_we), .waddr (index_ff), .wdata (use_wdata),
      .raddr (index_ff), .rdata (use_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         busy_ff     <= '0;
         holds_ff    <= '0;
         uvld_ff     <= '0;
         now_ff      <= '0;
         busy_cnt_ff <= '0;
         idle_cnt_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            stat_ff[k] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req;
                  idx_ff     <= '0;
                  index_ff   <= '0;
                  changed_ff <= '0;
                  status_ff  <= ST_OK;
                  uses_ff    <= '0;
                  reuse_ff   <= 1'b0;
                  unique case (req.operation)
                     OP_ACQUIRE: state_ff <= S_ACQ0;
                     OP_RELEASE: state_ff <= S_REL;
                     OP_SWEEP:   state_ff <= (idle_limit == 16'd0) ? S_DONE : S_SW_RD;
                     OP_PREWARM: state_ff <= (req.prewarm_limit == 5'd0) ? S_DONE : S_PRE;
                     OP_TICK: begin
                        now_ff   <= now_ff + 32'd1;
                        state_ff <= S_DONE;
                     end
                     default:    state_ff <= S_DONE;
                  endcase
               end
            end
            S_ACQ0: begin
               if (!busy_ff[idx_ff] && holds_ff[idx_ff] && vbit) begin
                  reuse_ff <= 1'b1;
                  index_ff <= idx_ff;
                  state_ff <= S_USE_RD;
               end else begin
                  // drop a stale idle resource on the way
                  if (!busy_ff[idx_ff] && holds_ff[idx_ff]) begin
                     holds_ff[idx_ff] <= 1'b0;
                     if (idle_cnt_ff != '0) idle_cnt_ff <= idle_cnt_ff - CW'(1);
                  end
                  if (last) begin
                     idx_ff   <= '0;
                     state_ff <= S_ACQ1;
                  end else begin
                     idx_ff <= IW'(idx_ff + IW'(1));
                  end
               end
            end
            S_ACQ1: begin
               if (!holds_ff[idx_ff]) begin
                  if (cbit) begin
                     index_ff <= idx_ff;
                     state_ff <= S_USE_RD;
                  end else begin
                     status_ff  <= ST_CREATE;
                     stat_ff[2] <= sat_inc(stat_ff[2]);
                     state_ff   <= S_DONE;
                  end
               end else if (last) begin
                  status_ff  <= ST_FULL;
                  stat_ff[3] <= sat_inc(stat_ff[3]);
                  state_ff   <= S_DONE;
               end else begin
                  idx_ff <= IW'(idx_ff + IW'(1));
               end
            end
            S_USE_RD: state_ff <= S_USE_WR;
            S_USE_WR: begin
               if (reuse_ff && idle_cnt_ff != '0) idle_cnt_ff <= idle_cnt_ff - CW'(1);
               holds_ff[index_ff] <= 1'b1;
               busy_ff[index_ff]  <= 1'b1;
               uvld_ff[index_ff]  <= 1'b1;
               uses_ff     <= use_wdata;
               busy_cnt_ff <= CW'(busy_cnt_ff + CW'(1));
               stat_ff[0]  <= sat_inc(stat_ff[0]);
               state_ff    <= S_DONE;
            end
            S_REL: begin
               if (tick_we) begin
                  busy_ff[tick_waddr] <= 1'b0;
                  if (busy_cnt_ff != '0) busy_cnt_ff <= busy_cnt_ff - CW'(1);
                  idle_cnt_ff <= CW'(idle_cnt_ff + CW'(1));
                  stat_ff[1]  <= sat_inc(stat_ff[1]);
                  index_ff    <= tick_waddr;
               end else begin
                  status_ff <= ST_NOT_FOUND;
               end
               state_ff <= S_DONE;
            end
            S_SW_RD: state_ff <= S_SW_CK;
            S_SW_CK: begin
               if (!busy_ff[idx_ff] && holds_ff[idx_ff]
                   && (now_ff - tick_rdata) >= 32'(idle_limit)) begin
                  holds_ff[idx_ff] <= 1'b0;
                  if (idle_cnt_ff != '0) idle_cnt_ff <= idle_cnt_ff - CW'(1);
                  changed_ff <= changed_in;
               end
               if (last) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= IW'(idx_ff + IW'(1));
                  state_ff <= S_SW_RD;
               end
            end
            S_PRE: begin
               if (tick_we) begin
                  holds_ff[idx_ff] <= 1'b1;
                  busy_ff[idx_ff]  <= 1'b0;
                  idle_cnt_ff <= CW'(idle_cnt_ff + CW'(1));
                  changed_ff  <= changed_in;
               end
               if (last || (tick_we && WW'(changed_in) >= WW'(req_ff.prewarm_limit))) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= IW'(idx_ff + IW'(1));
               end
            end
            S_DONE: begin
               if (taken) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_DONE);

   always_comb begin
      result.status         = status_ff;
      result.slot_index     = 4'(index_ff);
      result.slot_use_count = uses_ff;
      result.changed_count  = 5'(changed_ff);
      result.available      = (cap > busy_cnt_ff) ? 5'(cap - busy_cnt_ff) : 5'd0;
      result.busy_total     = 5'(busy_cnt_ff);
      result.idle_total     = 5'(idle_cnt_ff);
      result.acquired_total = stat_ff[0];
      result.released_total = stat_ff[1];
      result.failure_total  = stat_ff[2];
      result.full_total     = stat_ff[3];
   end
endmodule

/* src/resource_slot_pool_top.sv */
// ----------------------------------------------------------------------------
// resource_slot_pool_top
// Resource slot pool with idle timeout: registers, result buffer, sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  req_bus  | in  | valid/ready   | operation, handle, masks, prewarm_limit
//  rsp_bus  | out | valid/ready   | status, slot, counts, statistics
//  csr_*    | in  | write enable  | index 0 active_slots, 1 idle_limit
//
// One request at a time. The acquire and prewarm slot scans visit one slot per
// cycle; the sweep scan reads each slot's tick from the tick RAM before it
// checks that slot.
// Synchronous active-high reset clears all flags and counters; no clear pass.
// A result held in the output buffer stalls only the next completion.
// ----------------------------------------------------------------------------
module resource_slot_pool_top
   import rsp_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   rsp_req_if.sink     req_bus,
   rsp_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int CW = $clog2(NUM_SLOTS + 1);

   logic [4:0]    active_ff;
   logic [15:0]   limit_ff;
   logic [4:0]    cap_raw;
   logic [CW-1:0] cap;
   req_type       req;
   rsp_type       result, out_ff;
   logic          out_vld_ff;
   logic          done, taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'(DEFAULT_CAP);
         limit_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_SLOTS: active_ff <= csr_wdata[4:0];
            CSR_IDLE_LIMIT:   limit_ff  <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign cap_raw = (active_ff == 5'd0) ? 5'(DEFAULT_CAP) : active_ff;
   assign cap = (8'(cap_raw) > 8'(NUM_SLOTS)) ? CW'(NUM_SLOTS) : CW'(cap_raw);

   assign req.operation     = req_bus.operation;
   assign req.slot_handle   = req_bus.slot_handle;
   assign req.valid_mask    = req_bus.valid_mask;
   assign req.create_mask   = req_bus.create_mask;
   assign req.prewarm_limit = req_bus.prewarm_limit;

   rsp_core #(.NUM_SLOTS(NUM_SLOTS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req        (req),
      .cap        (cap),
      .idle_limit (limit_ff),
      .done       (done),
      .taken      (taken),
      .result     (result)
   );

   // load the buffer when it is empty or its beat leaves this cycle
   assign taken = done && (!out_vld_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (taken) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (taken) out_ff <= result;
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.slot_index     = out_ff.slot_index;
   assign rsp_bus.slot_use_count = out_ff.slot_use_count;
   assign rsp_bus.changed_count  = out_ff.changed_count;
   assign rsp_bus.available      = out_ff.available;
   assign rsp_bus.busy_total     = out_ff.busy_total;
   assign rsp_bus.idle_total     = out_ff.idle_total;
   assign rsp_bus.acquired_total = out_ff.acquired_total;
   assign rsp_bus.released_total = out_ff.released_total;
   assign rsp_bus.failure_total  = out_ff.failure_total;
   assign rsp_bus.full_total     = out_ff.full_total;

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while previous one in flight");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (8'(out_ff.busy_total) + 8'(out_ff.idle_total) <= 8'(NUM_SLOTS)))
      else $error("busy plus idle exceeds slot count");
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.status != ST_OK) |->
      (out_ff.slot_index == 4'd0 && out_ff.slot_use_count == 32'd0))
      else $error("failed operation reports a slot");
`endif
endmodule

/* dv/resource_slot_pool_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resource_slot_pool_top_tb
// Drives acquire, release, sweep, prewarm, tick and unknown-code beats into the
// slot pool under changing capacity and idle timeout. A local slot pool model
// predicts every result beat, and each beat is compared field by field.
// ----------------------------------------------------------------------------
module resource_slot_pool_top_tb;
   import rsp_pkg::*;

   localparam int SLOTS = 16;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   rsp_req_if req_bus ();
   rsp_rsp_if rsp_bus ();

   resource_slot_pool_top #(.NUM_SLOTS(SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // pool model state
   bit          pool_busy [SLOTS];
   bit          pool_holds[SLOTS];
   logic [31:0] pool_last [SLOTS];
   logic [31:0] pool_uses [SLOTS];
   logic [31:0] pool_now;
   int          busy_cnt, idle_cnt;
   logic [31:0] n_acquired, n_released, n_failed, n_full;
   logic [4:0]  cfg_slots;
   logic [15:0] cfg_limit;

   rsp_type     pending_rsp[$];
   int          fail_count;
   int          beats_sent, beats_seen;
   int          src_idle, snk_idle;
   int          hold_left;

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic int pool_cap();
      if (cfg_slots == 5'd0) return int'(DEFAULT_CAP);
      return (cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots);
   endfunction

   function automatic rsp_type pool_step(req_type r);
      rsp_type o;
      int      cap;
      int      idx;
      bit      found, reused;
      o      = '0;
      cap    = pool_cap();
      found  = 1'b0;
      reused = 1'b0;
      idx    = 0;
      case (r.operation)
         OP_ACQUIRE: begin
            for (int i = 0; i < cap && !found; i++) begin
               if (!pool_busy[i] && pool_holds[i]) begin
                  if (r.valid_mask[i]) begin
                     found = 1'b1; reused = 1'b1; idx = i;
                  end else begin
                     // drop the stale resource passed over
                     pool_holds[i] = 1'b0;
                     if (idle_cnt > 0) idle_cnt--;
                  end
               end
            end
            for (int i = 0; i < cap && !found; i++) begin
               if (!pool_holds[i]) begin
                  found = 1'b1; idx = i;
               end
            end
            if (!found) begin
               o.status = ST_FULL;
               n_full   = bump(n_full);
            end else if (!reused && !r.create_mask[idx]) begin
               o.status = ST_CREATE;
               n_failed = bump(n_failed);
            end else begin
               if (reused && idle_cnt > 0) idle_cnt--;
               pool_holds[idx]  = 1'b1;
               pool_busy[idx]   = 1'b1;
               pool_uses[idx]   = bump(pool_uses[idx]);
               o.slot_index     = idx[3:0];
               o.slot_use_count = pool_uses[idx];
               busy_cnt++;
               n_acquired = bump(n_acquired);
            end
         end
         OP_RELEASE: begin
            if (r.slot_handle < cap && pool_busy[r.slot_handle]) begin
               pool_busy[r.slot_handle] = 1'b0;
               pool_last[r.slot_handle] = pool_now;
               if (busy_cnt > 0) busy_cnt--;
               idle_cnt++;
               n_released   = bump(n_released);
               o.slot_index = r.slot_handle;
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
         OP_SWEEP: begin
            if (cfg_limit != 16'd0) begin
               for (int i = 0; i < cap; i++) begin
                  if (!pool_busy[i] && pool_holds[i] &&
                      (pool_now - pool_last[i]) >= {16'd0, cfg_limit}) begin
                     pool_holds[i] = 1'b0;
                     if (idle_cnt > 0) idle_cnt--;
                     o.changed_count++;
                  end
               end
            end
         end
         OP_PREWARM: begin
            for (int i = 0; i < cap && o.changed_count < r.prewarm_limit; i++) begin
               if (!pool_holds[i] && r.create_mask[i]) begin
                  pool_holds[i] = 1'b1;
                  pool_busy[i]  = 1'b0;
                  pool_last[i]  = pool_now;
                  idle_cnt++;
                  o.changed_count++;
               end
            end
         end
         OP_TICK: pool_now = pool_now + 32'd1;
         default: ;
      endcase
      o.available      = (cap > busy_cnt) ? 5'(cap - busy_cnt) : 5'd0;
      o.busy_total     = 5'(busy_cnt);
      o.idle_total     = 5'(idle_cnt);
      o.acquired_total = n_acquired;
      o.released_total = n_released;
      o.failure_total  = n_failed;
      o.full_total     = n_full;
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_seen++;
         if (pending_rsp.size() == 0) begin
            report("unexpected result beat", 32'd1, 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 32'(rsp_bus.status), 32'(want.status));
            check_field("slot_index", 32'(rsp_bus.slot_index), 32'(want.slot_index));
            check_field("slot_use_count", rsp_bus.slot_use_count, want.slot_use_count);
            check_field("changed_count", 32'(rsp_bus.changed_count),
                        32'(want.changed_count));
            check_field("available", 32'(rsp_bus.available), 32'(want.available));
            check_field("busy_total", 32'(rsp_bus.busy_total), 32'(want.busy_total));
            check_field("idle_total", 32'(rsp_bus.idle_total), 32'(want.idle_total));
            check_field("acquired_total", rsp_bus.acquired_total, want.acquired_total);
            check_field("released_total", rsp_bus.released_total, want.released_total);
            check_field("failure_total", rsp_bus.failure_total, want.failure_total);
            check_field("full_total", rsp_bus.full_total, want.full_total);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= snk_idle);
      end
   end

   task automatic send_beat(req_type r);
      if ($urandom_range(99) < src_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= r.operation;
      req_bus.slot_handle   <= r.slot_handle;
      req_bus.valid_mask    <= r.valid_mask;
      req_bus.create_mask   <= r.create_mask;
      req_bus.prewarm_limit <= r.prewarm_limit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(pool_step(r));
      beats_sent++;
   endtask

   task automatic send_op(logic [2:0] op, logic [3:0] h, logic [15:0] vm, logic [15:0] cm,
                          logic [4:0] pl);
      req_type r;
      r = '{operation: op, slot_handle: h, valid_mask: vm, create_mask: cm,
            prewarm_limit: pl};
      send_beat(r);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      // let an acquire scan over a full pool finish
      repeat (2 * SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ACTIVE_SLOTS) cfg_slots = data[4:0];
      else cfg_limit = data;
   endtask

   task automatic set_config(logic [4:0] slots, logic [15:0] limit);
      drain();
      write_reg(CSR_ACTIVE_SLOTS, {11'd0, slots});
      write_reg(CSR_IDLE_LIMIT, limit);
   endtask

   function automatic req_type random_req();
      req_type r;
      int      pick;
      int      busy_list[$];
      pick            = $urandom_range(99);
      r.valid_mask    = 16'($urandom | $urandom | $urandom);
      r.create_mask   = 16'($urandom | $urandom);
      r.slot_handle   = 4'($urandom_range(15));
      r.prewarm_limit = 5'($urandom_range(16));
      if ($urandom_range(9) == 0) r.valid_mask  = 16'($urandom);
      if ($urandom_range(15) == 0) r.create_mask = 16'($urandom);
      if (pick < 36)      r.operation = OP_ACQUIRE;
      else if (pick < 66) r.operation = OP_RELEASE;
      else if (pick < 74) r.operation = OP_SWEEP;
      else if (pick < 82) r.operation = OP_PREWARM;
      else if (pick < 97) r.operation = OP_TICK;
      else                r.operation = 3'($urandom_range(7, 5));
      if (r.operation == OP_RELEASE && $urandom_range(9) < 8) begin
         for (int i = 0; i < pool_cap(); i++) if (pool_busy[i]) busy_list.push_back(i);
         if (busy_list.size() != 0)
            r.slot_handle = 4'(busy_list[$urandom_range(busy_list.size() - 1)]);
      end
      return r;
   endfunction

   task automatic test_directed();
      // default capacity of eight
      send_op(OP_ACQUIRE, 4'd0, 16'hFFFF, 16'h0000, 5'd0);   // create fails
      for (int i = 0; i < 8; i++) send_op(OP_ACQUIRE, 4'd0, 16'hFFFF, 16'hFFFF, 5'd0);
      send_op(OP_ACQUIRE, 4'd0, 16'hFFFF, 16'hFFFF, 5'd0);   // pool full
      send_op(OP_RELEASE, 4'd15, 16'h0, 16'h0, 5'd0);        // handle above cap
      send_op(OP_RELEASE, 4'd2, 16'h0, 16'h0, 5'd0);
      send_op(OP_RELEASE, 4'd2, 16'h0, 16'h0, 5'd0);         // not busy
      send_op(OP_RELEASE, 4'd5, 16'h0, 16'h0, 5'd0);
      send_op(OP_TICK, 4'd0, 16'h0, 16'h0, 5'd0);
      send_op(OP_ACQUIRE, 4'd0, 16'hFFFB, 16'h0000, 5'd0);   // drop slot 2, reuse 5
      send_op(OP_SWEEP, 4'd0, 16'h0, 16'h0, 5'd0);           // timeout disabled
      send_op(OP_PREWARM, 4'd0, 16'h0, 16'hFFFF, 5'd16);
      send_op(OP_PREWARM, 4'd0, 16'h0, 16'hFFFF, 5'd0);
      send_op(3'd5, 4'd0, 16'hFFFF, 16'hFFFF, 5'd31);
      send_op(3'd6, 4'd0, 16'h0, 16'h0, 5'd0);
      send_op(3'd7, 4'd15, 16'hFFFF, 16'hFFFF, 5'd16);
      send_op(OP_RELEASE, 4'd7, 16'h0, 16'h0, 5'd0);
      send_op(OP_ACQUIRE, 4'd0, 16'h0000, 16'h0000, 5'd0);   // drop idle, create fails
   endtask

   task automatic test_config_and_timeout();
      set_config(5'd16, 16'd1);
      send_op(OP_PREWARM, 4'd0, 16'h0, 16'h8001, 5'd16);
      send_op(OP_SWEEP, 4'd0, 16'h0, 16'h0, 5'd0);
      send_op(OP_TICK, 4'd0, 16'h0, 16'h0, 5'd0);
      send_op(OP_SWEEP, 4'd0, 16'h0, 16'h0, 5'd0);
      set_config(5'd1, 16'hFFFF);
      send_op(OP_ACQUIRE, 4'd0, 16'hFFFF, 16'hFFFF, 5'd0);
      send_op(OP_SWEEP, 4'd0, 16'h0, 16'h0, 5'd0);
   endtask

   task automatic test_random();
      logic [4:0]  slot_set [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd12};
      logic [15:0] limit_set[6] = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd2, 16'd6};
      for (int mode = 0; mode < 3; mode++) begin
         src_idle = (mode == 0) ? 22 : (mode == 1) ? 65 : 0;
         snk_idle = (mode == 0) ? 65 : (mode == 1) ? 22 : 0;
         for (int c = 0; c < 6; c++) begin
            set_config(slot_set[c], limit_set[c]);
            for (int n = 0; n < 83; n++) send_beat(random_req());
         end
      end
   endtask

   task automatic test_backpressure();
      src_idle  = 0;
      snk_idle  = 0;
      hold_left = 400;
      for (int n = 0; n < 12; n++) send_beat(random_req());
      // hold until the pool has answered everything
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      for (int n = 0; n < 12; n++) send_beat(random_req());
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_ACTIVE_SLOTS;
      csr_wdata               <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.operation       <= OP_TICK;
      req_bus.slot_handle     <= '0;
      req_bus.valid_mask      <= '0;
      req_bus.create_mask     <= '0;
      req_bus.prewarm_limit   <= '0;
      fail_count = 0;
      beats_sent = 0;
      beats_seen = 0;
      hold_left  = 0;
      src_idle   = 22;
      snk_idle   = 65;
      for (int i = 0; i < SLOTS; i++) begin
         pool_busy[i] = 0; pool_holds[i] = 0; pool_last[i] = '0; pool_uses[i] = '0;
      end
      pool_now = '0; busy_cnt = 0; idle_cnt = 0;
      n_acquired = '0; n_released = '0; n_failed = '0; n_full = '0;
      cfg_slots = 5'd8; cfg_limit = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_and_timeout();
      test_backpressure();
      test_random();
      drain();

      $display("Covered %0d request beats and %0d result beats over capacities 1 to 31",
               beats_sent, beats_seen);
      $display("and idle timeouts from off to 65535, with stalls on both channels.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
src/rsp_pkg.sv
src/rsp_req_if.sv
src/rsp_rsp_if.sv
src/rsp_ram.sv
src/rsp_core.sv
src/resource_slot_pool_top.sv
dv/resource_slot_pool_top_tb.sv
